[hw/rtl/deque_with_insert_core_macros.svh]
// ----------------------------------------------------------------------------
// Deque core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_INSERT_CORE_MACROS_SVH
`define DEQUE_WITH_INSERT_CORE_MACROS_SVH

// Same-cycle implication.
`define DWI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DWI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dwi_pkg.sv]
// ----------------------------------------------------------------------------
// Deque core package
// Field widths, command and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
package dwi_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_READ_IDX   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_WRITE_IDX  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FILL       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd8;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
  } out_item_t;

endpackage

[hw/rtl/dwi_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dwi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/deque_with_insert_core.sv]
// ----------------------------------------------------------------------------
// Double-ended queue with positional insert
// Circular store of DEPTH entries driven by a small command sequencer.
// ----------------------------------------------------------------------------
// Usage: one command enters on the in_ channel (valid/ready) and exactly one
// result leaves on the out_ channel with data, status and the new length.
// The block takes one command at a time; in_ready is high only while the
// sequencer is idle. Push, write, refused and unknown commands pass straight
// to the result; pop, peek and read index first read the entry RAM; insert
// at the back writes at once, any other insert shifts the entries from the
// position back one slot each, from the back, then writes the value; fill
// writes the value into every live entry. Insert and fill are bound by the
// single write port of the entry RAM: insert moves one entry per cycle
// toward the back, fill writes one entry per cycle. The result sits in an
// output register, so the next command is accepted while it waits. If the
// receiver stalls and a second result is ready, the sequencer holds it and
// does not take a new command until the register frees. Reset (rst_n low,
// synchronous) empties the queue and head goes to 0; the entry RAM is not
// cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
`include "deque_with_insert_core_macros.svh"

module deque_with_insert_core #(
  parameter int DEPTH      = dwi_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dwi_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dwi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dwi_pkg::out_item_t out_data
);

  import dwi_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_INS   = 6'b001000,
    S_FILL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [AW-1:0]       wptr_r, wptr_nxt;
  logic [AW-1:0]       rptr_r, rptr_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_W-1:0]   res_data_r, res_data_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [LEN_W-1:0]    res_len_r, res_len_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_q_r, out_q_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [DATA_WIDTH-1:0] val_w;
  logic [CNT_W-1:0]      off;
  logic [AW-1:0]         slot;
  logic [CMP_W-1:0]      pos_x, cnt_x;
  logic                  full, empty, accept;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  // Both operands stay below DEPTH + 1, so one subtract folds the sum back.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h,
                                             input logic [CNT_W-1:0] o);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(h) + (CNT_W + 1)'(o);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  dwi_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign val_w     = DATA_WIDTH'(in_data.value);
  assign pos_x     = CMP_W'(in_data.position);
  assign cnt_x     = CMP_W'(count_r);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  // Logical offset of the slot the command touches first.
  always_comb begin
    unique case (in_data.command)
      CMD_PUSH_BACK, CMD_INSERT:    off = count_r;
      CMD_POP_BACK, CMD_PEEK_BACK:  off = count_r - CNT_W'(1);
      CMD_READ_IDX, CMD_WRITE_IDX:  off = CNT_W'(in_data.position);
      default:                      off = '0;
    endcase
  end

  assign slot = wrap_add(head_r, off);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    wptr_nxt       = wptr_r;
    rptr_nxt       = rptr_r;
    rem_nxt        = rem_r;
    val_nxt        = val_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    res_len_nxt    = res_len_r;
    out_q_nxt      = out_q_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_we         = 1'b0;
    ram_waddr      = wptr_r;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = rptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt        = val_w;
          res_data_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          unique case (in_data.command)
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                head_nxt  = ptr_dec(head_r);
                ram_we    = 1'b1;
                ram_waddr = ptr_dec(head_r);
                ram_wdata = val_w;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot;
                ram_wdata = val_w;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot;
                state_nxt = S_READ;
                if (in_data.command == CMD_POP_FRONT) begin
                  head_nxt = ptr_inc(head_r);
                end
                if (in_data.command == CMD_POP_FRONT ||
                    in_data.command == CMD_POP_BACK) begin
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                res_status_nxt = ST_BADPOS;
              end else if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                if (pos_x == cnt_x) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot;
                  ram_wdata = val_w;
                end else begin
                  // Start the walk at the back: read slot n-1, write it to slot n.
                  wptr_nxt  = slot;
                  rptr_nxt  = ptr_dec(slot);
                  ram_re    = 1'b1;
                  ram_raddr = ptr_dec(slot);
                  rem_nxt   = count_r - CNT_W'(in_data.position);
                  state_nxt = S_SHIFT;
                end
              end
            end
            CMD_READ_IDX: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot;
                state_nxt = S_READ;
              end
            end
            CMD_WRITE_IDX: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot;
                ram_wdata = val_w;
              end
            end
            CMD_FILL: begin
              if (!empty) begin
                wptr_nxt  = head_r;
                rem_nxt   = count_r;
                state_nxt = S_FILL;
              end
            end
            default: begin
            end
          endcase
          res_len_nxt = LEN_W'(count_nxt);
        end
      end
      S_READ: begin
        res_data_nxt = DATA_W'(ram_rdata);
        state_nxt    = S_DONE;
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_r;
        ram_wdata = ram_rdata;
        wptr_nxt  = rptr_r;
        rem_nxt   = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_INS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_dec(rptr_r);
          rptr_nxt  = ptr_dec(rptr_r);
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_r;
        ram_wdata = val_r;
        state_nxt = S_DONE;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_r;
        ram_wdata = val_r;
        wptr_nxt  = ptr_inc(wptr_r);
        rem_nxt   = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_q_nxt.data   = res_data_r;
          out_q_nxt.status = res_status_r;
          out_q_nxt.length = res_len_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wptr_r       <= wptr_nxt;
    rptr_r       <= rptr_nxt;
    rem_r        <= rem_nxt;
    val_r        <= val_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    res_len_r    <= res_len_nxt;
    out_q_r      <= out_q_nxt;
  end

  `DWI_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH),
                  "live entry count exceeds capacity")
  `DWI_ASSERT_NXT(a_busy_after_accept, accept, !in_ready,
                  "sequencer accepted a transaction but stayed idle")
  `DWI_ASSERT_IMP(a_walk_nonzero, (state_r == S_SHIFT || state_r == S_FILL),
                  rem_r != '0, "entry walk running with no entries left")
  `DWI_ASSERT_IMP(a_shift_no_collide, (state_r == S_SHIFT && ram_re),
                  ram_waddr != ram_raddr, "insert shift reads the slot it writes")

endmodule
